/* hw/rtl/mlcm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mlcm_pkg;
  localparam int LIMB_COUNT = 64;
  localparam int LIMB_W = 32;
  localparam int IDX_W = $clog2(LIMB_COUNT);
  localparam int CNT_W = $clog2(LIMB_COUNT + 1);
  localparam int OUT_IDX_W = 6;

  typedef enum logic [1:0] {
    REQ_SET  = 2'd0,
    REQ_FOLD = 2'd1,
    REQ_READ = 2'd2,
    REQ_BAD  = 2'd3
  } req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SET_HI,
    ST_MOD_RD,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_GCD,
    ST_DIV_RD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_TRIM,
    ST_TRIM_WAIT,
    ST_MUL_RD,
    ST_MUL_GO,
    ST_MUL_WB,
    ST_MUL_TOP,
    ST_READ_RD,
    ST_READ_OUT,
    ST_DONE
  } state_t;

  typedef enum logic {
    DV_MOD,
    DV_DIV
  } dvmode_t;

  typedef struct packed {
    logic           load_set;
    logic           set_hi;
    logic           load_fold;
    logic           rd_en;
    logic           div_start;
    dvmode_t        div_mode;
    logic           rem_ld;
    logic           div_wb;
    logic           gcd_start;
    logic           trim_step;
    logic           mul_start;
    logic           mul_wb;
    logic           mul_top;
    logic           rem_clr;
    logic           idx_load_top;
    logic           idx_load_zero;
    logic           idx_dec;
    logic           idx_inc;
    logic           emit_limb;
    logic           emit_plain;
    logic           emit_bad;
  } ctrl_t;

  typedef struct packed {
    logic div_busy;
    logic idx_zero;
    logic idx_last;
    logic gcd_done;
    logic top_zero;
    logic in_use_one;
  } stat_t;
endpackage
`default_nettype wire

/* hw/rtl/multiprecision_lcm_accumulator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Multiprecision lcm accumulator over 64 limbs of 32 bits. Raise start with
// in_req_type and in_operand; the request is taken at the edge where busy is
// low. Set and fold give one transaction on out_valid, read gives one per limb
// in use; the receiver cannot stall, each result is on the ports for one cycle.
// A refused request answers in the cycle after it is taken and leaves busy low.
// A set writes the low limb, then the high limb. A read fetches and emits each
// limb in turn. A fold walks the limbs twice through a radix-2 divider (mod,
// then divide by the gcd), runs Euclid on the same divider, trims zero top
// limbs, then multiplies the limbs by the operand from the bottom up.
module multiprecision_lcm_accumulator_top
  import mlcm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_req_type,
  input  wire logic [63:0]           in_operand,
  output logic                       out_valid,
  output logic [LIMB_W-1:0]          out_limb_word,
  output logic [OUT_IDX_W-1:0]       out_limb_index,
  output logic                       out_last_item,
  output logic                       out_overflow_seen,
  output logic                       out_status
);
  ctrl_t ctl;
  stat_t st;
  logic  bad_y;

  mlcm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .req(in_req_type), .bad_y(bad_y),
    .st(st), .busy(busy), .ctl(ctl)
  );

  mlcm_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_operand(in_operand), .ctl(ctl), .st(st),
    .bad_y(bad_y), .out_valid(out_valid), .out_limb_word(out_limb_word),
    .out_limb_index(out_limb_index), .out_last_item(out_last_item),
    .out_overflow_seen(out_overflow_seen), .out_status(out_status)
  );
endmodule
`default_nettype wire

/* hw/rtl/mlcm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module mlcm_ctrl
  import mlcm_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [1:0]     req,
  input  wire logic           bad_y,
  input  wire stat_t          st,
  output logic                busy,
  output ctrl_t               ctl
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    ctl          = '0;
    ctl.div_mode = DV_MOD;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (req_t'(req))
            REQ_SET: begin
              ctl.load_set = 1'b1;
              state_nxt    = ST_SET_HI;
            end
            REQ_FOLD: begin
              if (bad_y) begin
                ctl.emit_bad = 1'b1;
              end else begin
                ctl.load_fold    = 1'b1;
                ctl.idx_load_top = 1'b1;
                ctl.rem_clr      = 1'b1;
                state_nxt        = ST_MOD_RD;
              end
            end
            REQ_READ: begin
              ctl.idx_load_zero = 1'b1;
              state_nxt         = ST_READ_RD;
            end
            REQ_BAD: ctl.emit_bad = 1'b1;
          endcase
        end
      end
      ST_SET_HI: begin
        ctl.set_hi = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_MOD_RD: begin
        ctl.rd_en = 1'b1;
        state_nxt = ST_MOD_GO;
      end
      ST_MOD_GO: begin
        ctl.div_start = 1'b1;
        ctl.div_mode  = DV_MOD;
        state_nxt     = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        if (!st.div_busy) begin
          ctl.rem_ld = 1'b1;
          if (st.idx_zero) begin
            ctl.gcd_start = 1'b1;
            state_nxt     = ST_GCD;
          end else begin
            ctl.idx_dec = 1'b1;
            state_nxt   = ST_MOD_RD;
          end
        end
      end
      ST_GCD: begin
        if (st.gcd_done) begin
          ctl.idx_load_top = 1'b1;
          ctl.rem_clr      = 1'b1;
          state_nxt        = ST_DIV_RD;
        end
      end
      ST_DIV_RD: begin
        ctl.rd_en = 1'b1;
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        ctl.div_start = 1'b1;
        ctl.div_mode  = DV_DIV;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!st.div_busy) begin
          ctl.div_wb = 1'b1;
          ctl.rem_ld = 1'b1;
          if (st.idx_zero) begin
            state_nxt = ST_TRIM;
          end else begin
            ctl.idx_dec = 1'b1;
            state_nxt   = ST_DIV_RD;
          end
        end
      end
      ST_TRIM: begin
        if (!st.in_use_one && st.top_zero) begin
          ctl.trim_step = 1'b1;
          state_nxt     = ST_TRIM_WAIT;
        end else begin
          ctl.idx_load_zero = 1'b1;
          ctl.rem_clr       = 1'b1;
          state_nxt         = ST_MUL_RD;
        end
      end
      // top limb register catches up with the new count
      ST_TRIM_WAIT: state_nxt = ST_TRIM;
      ST_MUL_RD: begin
        ctl.rd_en = 1'b1;
        state_nxt = ST_MUL_GO;
      end
      ST_MUL_GO: begin
        ctl.mul_start = 1'b1;
        state_nxt     = ST_MUL_WB;
      end
      ST_MUL_WB: begin
        ctl.mul_wb = 1'b1;
        if (st.idx_last) begin
          state_nxt = ST_MUL_TOP;
        end else begin
          ctl.idx_inc = 1'b1;
          state_nxt   = ST_MUL_RD;
        end
      end
      ST_MUL_TOP: begin
        ctl.mul_top = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        ctl.emit_plain = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_READ_RD: begin
        ctl.rd_en = 1'b1;
        state_nxt = ST_READ_OUT;
      end
      ST_READ_OUT: begin
        ctl.emit_limb = 1'b1;
        if (st.idx_last) begin
          state_nxt = ST_IDLE;
        end else begin
          ctl.idx_inc = 1'b1;
          state_nxt   = ST_READ_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* hw/rtl/mlcm_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module mlcm_dp
  import mlcm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [63:0]          in_operand,
  input  wire ctrl_t                ctl,
  output stat_t                     st,
  output logic                      bad_y,
  output logic                      out_valid,
  output logic [LIMB_W-1:0]         out_limb_word,
  output logic [OUT_IDX_W-1:0]      out_limb_index,
  output logic                      out_last_item,
  output logic                      out_overflow_seen,
  output logic                      out_status
);
  logic [LIMB_W-1:0] mem [LIMB_COUNT];
  logic [LIMB_W-1:0] rd_r;
  logic [LIMB_W-1:0] top_r;
  logic [CNT_W-1:0]  use_r;
  logic              ovf_r;
  logic [IDX_W-1:0]  idx_r;
  logic [LIMB_W-1:0] y_r;
  logic [LIMB_W-1:0] g_r;
  logic [LIMB_W-1:0] rem_r;

  // shared restoring divider: (hi:lo) / d with hi < d, one quotient bit per cycle
  logic [LIMB_W-1:0] dv_rem_r;
  logic [LIMB_W-1:0] dv_q_r;
  logic [LIMB_W-1:0] dv_d_r;
  logic [4:0]        dv_cnt_r;
  logic              dv_busy_r;
  logic [LIMB_W:0]   dv_sh;
  logic [LIMB_W:0]   dv_sub;
  logic              dv_go;
  logic [LIMB_W-1:0] dv_hi, dv_lo, dv_dd;

  // Euclid on a, b; each step takes a mod b on the divider
  logic [LIMB_W-1:0] ga_r, gb_r;
  logic              g_busy_r, g_wait_r;
  logic              gcd_go;
  logic              gcd_done;

  logic [2*LIMB_W-1:0] prod_r;
  logic [LIMB_W-1:0]   carry_r;
  logic [2*LIMB_W-1:0] mul_sum;

  assign bad_y = (in_operand == 64'd0) || (in_operand[63:32] != 32'd0);

  assign dv_sh  = {dv_rem_r, dv_q_r[LIMB_W-1]};
  assign dv_sub = dv_sh - {1'b0, dv_d_r};

  assign gcd_go   = g_busy_r && !g_wait_r && (gb_r != '0);
  assign gcd_done = g_busy_r && !g_wait_r && (gb_r == '0);

  always_comb begin
    dv_go = ctl.div_start || gcd_go;
    if (ctl.div_start) begin
      dv_hi = rem_r;
      dv_lo = rd_r;
      dv_dd = (ctl.div_mode == DV_DIV) ? g_r : y_r;
    end else begin
      dv_hi = '0;
      dv_lo = ga_r;
      dv_dd = gb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_go) begin
      dv_rem_r <= dv_hi;
      dv_q_r   <= dv_lo;
      dv_d_r   <= dv_dd;
      dv_cnt_r <= '0;
    end else if (dv_busy_r) begin
      dv_cnt_r <= dv_cnt_r + 5'd1;
      if (!dv_sub[LIMB_W]) begin
        dv_rem_r <= dv_sub[LIMB_W-1:0];
        dv_q_r   <= {dv_q_r[LIMB_W-2:0], 1'b1};
      end else begin
        dv_rem_r <= dv_sh[LIMB_W-1:0];
        dv_q_r   <= {dv_q_r[LIMB_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
    end else if (dv_go) begin
      dv_busy_r <= 1'b1;
    end else if (dv_busy_r && dv_cnt_r == 5'd31) begin
      dv_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_busy_r <= 1'b0;
      g_wait_r <= 1'b0;
    end else if (ctl.gcd_start) begin
      g_busy_r <= 1'b1;
      g_wait_r <= 1'b0;
    end else if (g_busy_r) begin
      if (!g_wait_r) begin
        if (gb_r == '0) begin
          g_busy_r <= 1'b0;
        end else begin
          g_wait_r <= 1'b1;
        end
      end else if (!dv_busy_r) begin
        g_wait_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.gcd_start) begin
      ga_r <= dv_rem_r;
      gb_r <= y_r;
    end else if (g_busy_r && g_wait_r && !dv_busy_r) begin
      ga_r <= gb_r;
      gb_r <= dv_rem_r;
    end
    if (gcd_done) begin
      g_r <= ga_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_start) begin
      prod_r <= (2*LIMB_W)'(rd_r) * (2*LIMB_W)'(y_r);
    end
  end

  assign mul_sum = prod_r + (2*LIMB_W)'(carry_r);

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_r <= mem[idx_r];
    end
    top_r <= mem[IDX_W'(use_r - 1'b1)];
    if (!rst_n) begin
      mem[0] <= LIMB_W'(1);
    end else if (ctl.load_set) begin
      mem[0] <= in_operand[31:0];
    end else if (ctl.set_hi) begin
      mem[1] <= y_r;
    end else if (ctl.div_wb) begin
      mem[idx_r] <= dv_q_r;
    end else if (ctl.mul_wb) begin
      mem[idx_r] <= mul_sum[LIMB_W-1:0];
    end else if (ctl.mul_top && carry_r != '0 && use_r != CNT_W'(LIMB_COUNT)) begin
      mem[use_r[IDX_W-1:0]] <= carry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r <= CNT_W'(1);
      ovf_r <= 1'b0;
    end else if (ctl.load_set) begin
      use_r <= (in_operand[63:32] != '0) ? CNT_W'(2) : CNT_W'(1);
      ovf_r <= 1'b0;
    end else if (ctl.trim_step) begin
      use_r <= use_r - 1'b1;
    end else if (ctl.mul_top && carry_r != '0) begin
      if (use_r != CNT_W'(LIMB_COUNT)) begin
        use_r <= use_r + 1'b1;
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.idx_load_top) begin
      idx_r <= IDX_W'(use_r - 1'b1);
    end else if (ctl.idx_load_zero) begin
      idx_r <= '0;
    end else if (ctl.idx_dec) begin
      idx_r <= idx_r - 1'b1;
    end else if (ctl.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    if (ctl.rem_clr) begin
      rem_r   <= '0;
      carry_r <= '0;
    end else begin
      if (ctl.rem_ld) begin
        rem_r <= dv_rem_r;
      end
      if (ctl.mul_wb) begin
        carry_r <= mul_sum[2*LIMB_W-1:LIMB_W];
      end
    end
    if (ctl.load_set) begin
      y_r <= in_operand[63:32];
    end else if (ctl.load_fold) begin
      y_r <= in_operand[31:0];
    end
  end

  always_comb begin
    st            = '0;
    st.div_busy   = dv_busy_r;
    st.idx_zero   = (idx_r == '0);
    st.idx_last   = (CNT_W'(idx_r) == use_r - 1'b1);
    st.gcd_done   = gcd_done;
    st.top_zero   = (top_r == '0);
    st.in_use_one = (use_r == CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl.emit_limb || ctl.emit_plain || ctl.emit_bad;
    end
    out_limb_word     <= ctl.emit_limb ? rd_r : '0;
    out_limb_index    <= ctl.emit_limb ? OUT_IDX_W'(idx_r) : '0;
    out_last_item     <= ctl.emit_limb ? st.idx_last : 1'b1;
    out_status        <= ctl.emit_bad;
    out_overflow_seen <= ovf_r;
  end
endmodule
`default_nettype wire

/* hw/rtl/mlcm_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
module mlcm_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [31:0] out_limb_word,
  input wire logic       out_last_item,
  input wire logic       out_status
);
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last_item && out_limb_word == 32'd0)
    else $error("refused transaction carries data");
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("activity after reset");
  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !$past(start) |-> !out_valid || $past(busy))
    else $error("result without request");
endmodule

bind multiprecision_lcm_accumulator_top mlcm_chk u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_limb_word(out_limb_word), .out_last_item(out_last_item),
  .out_status(out_status)
);
`default_nettype wire
